FILE: design/c3rb_pkg.sv
// c3rb_pkg: shared types and constants of the 3x3 replicate-border convolution.
// Used by the top level, its port checker and the testbench; depends on nothing.
package c3rb_pkg;

	// Field and register widths
	localparam int PIX_W       = 8;
	localparam int COEF_W      = 16;
	localparam int PROD_W      = 25;
	localparam int CSUM_W      = 27;
	localparam int OUT_W       = 28;
	localparam int DIM_CFG_W   = 11;
	localparam int KROW_W      = 48;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 48;
	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 32;
	localparam int TUSER_IN_W  = 1;

	// Output queue
	localparam int OFIFO_DEPTH = 8;
	localparam int OFIFO_PTR_W = 3;
	localparam int OFIFO_CNT_W = 4;

	// Register reset values
	localparam logic [DIM_CFG_W-1:0] DIM_RESET  = 11'd1024;
	localparam logic [KROW_W-1:0]    KTOP_RESET = 48'h0000_0000_0000;
	localparam logic [KROW_W-1:0]    KMID_RESET = 48'h0000_0001_0000;
	localparam logic [KROW_W-1:0]    KBOT_RESET = 48'h0000_0000_0000;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 3'd0,
		CFG_FRAME_HEIGHT = 3'd1,
		CFG_KERNEL_TOP   = 3'd2,
		CFG_KERNEL_MID   = 3'd3,
		CFG_KERNEL_BOT   = 3'd4
	} cfg_reg_t;

	// Request kinds
	typedef enum logic {
		ACT_PIXEL = 1'b0,
		ACT_FLUSH = 1'b1
	} action_t;

	// One window column, index 0 top, 1 middle, 2 bottom
	typedef logic [2:0][PIX_W-1:0] col_t;

	// Control that rides with one step through the window stage
	typedef struct packed {
		logic emit;       // step produces a result
		logic right_rep;  // right-edge result: right column repeats center
		logic left_rep;   // left column repeats center
		logic top_rep;    // top row repeats middle
		logic bot_rep;    // bottom row repeats middle
		logic frame_end;  // last result of the frame
	} step_ctl_t;

endpackage

FILE: design/c3rb_ram.sv
// c3rb_ram: generic single-clock RAM, one write and one read port,
// registered read data. No dependencies.
module c3rb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/conv3x3_replicate_border.sv
// conv3x3_replicate_border: streaming 3x3 convolution with replicated border.
// Depends on c3rb_pkg and c3rb_ram (line store).
//
// Channel | Dir | Handshake            | Payload (low bit up)
// s_axis  | in  | tvalid / tready      | tdata[7:0] pixel_value; tuser[0] action
// m_axis  | out | tvalid / tready      | tdata[27:0] filtered_value, [31:28] zero;
//         |     |                      | tlast frame_end
// cfg     | in  | cfg_wr_en, no wait   | cfg_index, cfg_wr_data[47:0]
//
// One request per cycle sustained while the queue has room; a flush that meets a
// one-row frame holds input off for its second step, since both of its steps go
// through the single line-store read port. A request passes the line-store read,
// window, multiply and two adder levels before its result enters the queue. Reset
// clears counters, window and queue pointers; the line store needs no clearing
// pass, so requests are taken right after reset. Results wait in an 8-entry queue;
// input is held off when queue plus results in flight would fill it.
module conv3x3_replicate_border #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// pixel_value
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [c3rb_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
	// action
	input  logic [c3rb_pkg::TUSER_IN_W-1:0]    s_axis_tuser,
	// filtered_value, zero pad
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [c3rb_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
	output logic                               m_axis_tlast,
	input  logic                               cfg_wr_en,
	input  logic [c3rb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [c3rb_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
	import c3rb_pkg::*;

	localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WID_W  = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
	localparam int AREA   = MAX_WIDTH * MAX_HEIGHT;
	localparam int POS_W  = $clog2(AREA + 1);
	localparam int RST_WD = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int RST_HT = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
	localparam int LINE_W = 2 * PIX_W;

	// configuration registers
	logic [DIM_CFG_W-1:0] cfg_width_q;
	logic [DIM_CFG_W-1:0] cfg_height_q;
	logic [KROW_W-1:0]    krow_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= DIM_RESET;
			cfg_height_q <= DIM_RESET;
			krow_q[0]    <= KTOP_RESET;
			krow_q[1]    <= KMID_RESET;
			krow_q[2]    <= KBOT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FRAME_WIDTH:  cfg_width_q  <= cfg_wr_data[DIM_CFG_W-1:0];
				CFG_FRAME_HEIGHT: cfg_height_q <= cfg_wr_data[DIM_CFG_W-1:0];
				CFG_KERNEL_TOP:   krow_q[0]    <= cfg_wr_data[KROW_W-1:0];
				CFG_KERNEL_MID:   krow_q[1]    <= cfg_wr_data[KROW_W-1:0];
				CFG_KERNEL_BOT:   krow_q[2]    <= cfg_wr_data[KROW_W-1:0];
				default: ;
			endcase
		end
	end

	// effective frame size: zero acts as one, large values clamp
	logic [WID_W-1:0] w_eff;
	logic [ROW_W-1:0] h_eff;

	always_comb begin
		if (cfg_width_q == '0) begin
			w_eff = WID_W'(1);
		end else if (32'(cfg_width_q) > MAX_WIDTH) begin
			w_eff = WID_W'(MAX_WIDTH);
		end else begin
			w_eff = WID_W'(cfg_width_q);
		end
		if (cfg_height_q == '0) begin
			h_eff = ROW_W'(1);
		end else if (32'(cfg_height_q) > MAX_HEIGHT) begin
			h_eff = ROW_W'(MAX_HEIGHT);
		end else begin
			h_eff = ROW_W'(cfg_height_q);
		end
	end

	// frame area, registered off the config path
	logic [POS_W-1:0] area_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= POS_W'(RST_WD * RST_HT);
		end else begin
			area_q <= POS_W'(32'(w_eff) * 32'(h_eff));
		end
	end

	// ------------------------------------------------------------------
	// Step issue: counters, border flags, line-store read
	// ------------------------------------------------------------------
	logic [ADDR_W-1:0] col_q;
	logic [ROW_W-1:0]  row_q;
	logic [POS_W-1:0]  pos_q;
	logic              extra_q;

	logic              in_accept;
	logic              step_pix_req;
	logic              step_flush;
	logic              step_go;
	logic [PIX_W-1:0]  step_pix;
	logic              col0;
	logic [WID_W-1:0]  col_inc;
	logic [POS_W-1:0]  pos_inc;
	step_ctl_t         ctl;

	assign in_accept    = s_axis_tvalid && s_axis_tready;
	assign step_pix_req = in_accept && (action_t'(s_axis_tuser[0]) == ACT_PIXEL)
		&& (row_q < h_eff);
	assign step_flush   = in_accept && (action_t'(s_axis_tuser[0]) == ACT_FLUSH)
		&& (row_q >= h_eff);
	assign step_go      = step_pix_req || step_flush || extra_q;
	assign step_pix     = step_pix_req ? s_axis_tdata[PIX_W-1:0] : '0;
	assign col0         = (col_q == '0);
	assign col_inc      = WID_W'(col_q) + WID_W'(1);
	assign pos_inc      = pos_q + POS_W'(1);

	// a step at column zero closes the previous row; others emit one to the left
	always_comb begin
		ctl.emit      = col0 ? (row_q >= ROW_W'(2)) : (row_q != '0);
		ctl.right_rep = col0;
		ctl.left_rep  = col0 ? (w_eff == WID_W'(1)) : (col_q == ADDR_W'(1));
		ctl.top_rep   = col0 ? (row_q == ROW_W'(2)) : (row_q == ROW_W'(1));
		ctl.bot_rep   = col0 ? (row_q > h_eff) : (row_q >= h_eff);
		ctl.frame_end = ctl.emit && (pos_inc >= area_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			pos_q   <= '0;
			extra_q <= 1'b0;
		end else begin
			// one-row frame: a flush first takes an empty step, then a second one
			extra_q <= step_flush && !ctl.emit;
			if (step_go) begin
				if (ctl.frame_end) begin
					col_q <= '0;
					row_q <= '0;
					pos_q <= '0;
				end else begin
					if (col_inc >= w_eff) begin
						col_q <= '0;
						row_q <= row_q + ROW_W'(1);
					end else begin
						col_q <= col_inc[ADDR_W-1:0];
					end
					if (ctl.emit) begin
						pos_q <= pos_inc;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Line store: {older, newer} per column, read at issue, written in s1
	// ------------------------------------------------------------------
	logic              v_s1;
	step_ctl_t         ctl_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic [LINE_W-1:0] ram_rdata;
	logic [LINE_W-1:0] line_rd;
	logic [LINE_W-1:0] line_wr;
	logic              fwd_v_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic [LINE_W-1:0] fwd_data_q;

	c3rb_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (v_s1),
		.waddr(addr_s1),
		.wdata(line_wr),
		.re   (step_go),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	// write that landed on the edge of this read wins over the RAM output
	assign line_rd = (fwd_v_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : ram_rdata;
	assign line_wr = {line_rd[PIX_W-1:0], pix_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			fwd_v_q <= 1'b0;
		end else begin
			v_s1    <= step_go;
			fwd_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1     <= ctl;
		addr_s1    <= col_q;
		pix_s1     <= step_pix;
		fwd_addr_q <= addr_s1;
		fwd_data_q <= line_wr;
	end

	// ------------------------------------------------------------------
	// s1: window shift and border selection
	// ------------------------------------------------------------------
	col_t win_q [3];
	col_t new_col;
	col_t sel [3];

	assign new_col = {pix_s1, line_rd[PIX_W-1:0], line_rd[LINE_W-1:PIX_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= new_col;
		end
	end

	// left/center/right columns as seen before the shift, then edge replication
	always_comb begin
		col_t c_l;
		col_t c_c;
		col_t c_r;
		c_c = win_q[2];
		c_l = ctl_s1.left_rep ? win_q[2] : win_q[1];
		c_r = ctl_s1.right_rep ? win_q[2] : new_col;
		sel[0] = c_l;
		sel[1] = c_c;
		sel[2] = c_r;
		for (int x = 0; x < 3; x++) begin
			if (ctl_s1.top_rep) begin
				sel[x][0] = sel[x][1];
			end
			if (ctl_s1.bot_rep) begin
				sel[x][2] = sel[x][1];
			end
		end
	end

	// ------------------------------------------------------------------
	// s2: selected window, s3: products, s4: column sums, then final sum
	// ------------------------------------------------------------------
	logic                     v_s2;
	logic                     v_s3;
	logic                     v_s4;
	logic                     fend_s2;
	logic                     fend_s3;
	logic                     fend_s4;
	col_t                     pix_s2 [3];
	logic signed [PROD_W-1:0] prod_s3 [3][3];
	logic signed [CSUM_W-1:0] csum_s4 [3];
	logic signed [OUT_W-1:0]  total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && ctl_s1.emit;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		fend_s2 <= ctl_s1.frame_end;
		fend_s3 <= fend_s2;
		fend_s4 <= fend_s3;
		for (int x = 0; x < 3; x++) begin
			pix_s2[x] <= sel[x];
			for (int y = 0; y < 3; y++) begin
				prod_s3[x][y] <= $signed(krow_q[y][COEF_W*x +: COEF_W])
					* $signed({1'b0, pix_s2[x][y]});
			end
			csum_s4[x] <= CSUM_W'(prod_s3[x][0]) + CSUM_W'(prod_s3[x][1])
				+ CSUM_W'(prod_s3[x][2]);
		end
	end

	assign total = OUT_W'(csum_s4[0]) + OUT_W'(csum_s4[1]) + OUT_W'(csum_s4[2]);

	// ------------------------------------------------------------------
	// Output queue with credit on the input side
	// ------------------------------------------------------------------
	logic [OUT_W-1:0]       fifo_val_q  [OFIFO_DEPTH];
	logic                   fifo_last_q [OFIFO_DEPTH];
	logic [OFIFO_PTR_W-1:0] wptr_q;
	logic [OFIFO_PTR_W-1:0] rptr_q;
	logic [OFIFO_CNT_W-1:0] cnt_q;
	logic                   fifo_rd;
	logic [OFIFO_CNT_W:0]   committed;

	assign fifo_rd   = m_axis_tvalid && m_axis_tready;
	assign committed = (OFIFO_CNT_W + 1)'(cnt_q)
		+ (OFIFO_CNT_W + 1)'(v_s1 && ctl_s1.emit)
		+ (OFIFO_CNT_W + 1)'(v_s2) + (OFIFO_CNT_W + 1)'(v_s3)
		+ (OFIFO_CNT_W + 1)'(v_s4);
	assign s_axis_tready = !extra_q && (committed < (OFIFO_CNT_W + 1)'(OFIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (v_s4) begin
			fifo_val_q[wptr_q]  <= total;
			fifo_last_q[wptr_q] <= fend_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (v_s4) begin
				wptr_q <= wptr_q + OFIFO_PTR_W'(1);
			end
			if (fifo_rd) begin
				rptr_q <= rptr_q + OFIFO_PTR_W'(1);
			end
			cnt_q <= cnt_q + OFIFO_CNT_W'(v_s4) - OFIFO_CNT_W'(fifo_rd);
		end
	end

	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = TDATA_OUT_W'(fifo_val_q[rptr_q]);
	assign m_axis_tlast  = fifo_last_q[rptr_q];

endmodule

FILE: design/c3rb_checker.sv
// c3rb_checker: port-level assertions for conv3x3_replicate_border, and the
// bind that attaches them. Depends on c3rb_pkg.
module c3rb_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [c3rb_pkg::TUSER_IN_W-1:0]  s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [c3rb_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
	input logic                             m_axis_tlast
);
	import c3rb_pkg::*;

	logic in_req;
	logic flush_req;

	assign in_req    = s_axis_tvalid && s_axis_tready;
	assign flush_req = in_req && (action_t'(s_axis_tuser[0]) == ACT_FLUSH);

	// a waiting result holds its value and frame mark
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// pad bits above the sum stay zero
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[TDATA_OUT_W-1:OUT_W] == '0))
		else $error("result pad bits not zero");

	// a result that shows up on an empty output traces back to an accepted request,
	// or to a flush for the second step of a flush
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(in_req, 5) || $past(flush_req, 6))
		else $error("result without matching request");

endmodule

bind conv3x3_replicate_border c3rb_checker u_c3rb_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for conv3x3_replicate_border.
// Drives pixel and flush requests with random pacing, predicts every result
// with its own window model, and checks each result in order. Needs c3rb_pkg.
module testbench;
	import c3rb_pkg::*;

	localparam int          MAX_W         = 1024;
	localparam int          MAX_H         = 1024;
	localparam int          RAND_ITEMS    = 2000;
	localparam int          SETTLE_CYCLES = 16;
	localparam int unsigned CYCLE_LIMIT   = 2_000_000;
	localparam int          REPORT_MAX    = 10;

	// One expected output result
	typedef struct packed {
		logic [OUT_W-1:0] value;
		logic             last;
	} filtered_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [TDATA_IN_W-1:0]   s_axis_tdata;   // [7:0] pixel_value
	logic [TUSER_IN_W-1:0]   s_axis_tuser;   // [0] action
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [TDATA_OUT_W-1:0]  m_axis_tdata;   // [27:0] filtered_value, [31:28] zero
	logic                    m_axis_tlast;
	logic                    cfg_wr_en;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_wr_data;

	// Pacing of each side; cleared for stretches with no idling
	bit src_idle;
	bit snk_idle;

	int mismatch_count;

	// Predictor state
	logic [DIM_CFG_W-1:0] width_reg;
	logic [DIM_CFG_W-1:0] height_reg;
	logic [KROW_W-1:0]    kernel_reg [3];
	logic [PIX_W-1:0]     older_line [MAX_W];
	logic [PIX_W-1:0]     newer_line [MAX_W];
	logic [PIX_W-1:0]     win_pix [9];   // index col*3+row, col 0 left, row 0 top
	int unsigned          col_ptr;
	int unsigned          row_ptr;
	int unsigned          result_idx;

	filtered_t expected_filtered [$];

	conv3x3_replicate_border dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wr_data   (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Window predictor
	// ---------------------------------------------------------------

	function automatic void reset_prediction();
		width_reg     = DIM_RESET;
		height_reg    = DIM_RESET;
		kernel_reg[0] = KTOP_RESET;
		kernel_reg[1] = KMID_RESET;
		kernel_reg[2] = KBOT_RESET;
		for (int i = 0; i < MAX_W; i++) begin
			older_line[i] = '0;
			newer_line[i] = '0;
		end
		for (int i = 0; i < 9; i++)
			win_pix[i] = '0;
		col_ptr    = 0;
		row_ptr    = 0;
		result_idx = 0;
	endfunction

	function automatic int unsigned eff_width();
		if (width_reg == 0)
			return 1;
		if (width_reg > MAX_W)
			return MAX_W;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg == 0)
			return 1;
		if (height_reg > MAX_H)
			return MAX_H;
		return height_reg;
	endfunction

	function automatic logic signed [COEF_W-1:0] kernel_coef(int krow, int slot);
		return kernel_reg[krow][COEF_W*slot +: COEF_W];
	endfunction

	// Nine-tap sum; lc/cc/rc are window offsets of the three columns.
	// Out-of-frame neighbors fall back to the nearest edge pixel.
	function automatic longint window_sum(int lc, int cc, int rc, int unsigned ro,
			int unsigned co, int unsigned h);
		int     base [3];
		int     sy;
		longint acc;
		base[0] = (co == 0) ? cc : lc;
		base[1] = cc;
		base[2] = rc;
		acc     = 0;
		for (int x = 0; x < 3; x++) begin
			for (int y = 0; y < 3; y++) begin
				sy = y;
				if (y == 0 && ro == 0)
					sy = 1;
				if (y == 2 && ro + 1 >= h)
					sy = 1;
				acc += longint'(kernel_coef(y, x)) * longint'({1'b0, win_pix[base[x] + sy]});
			end
		end
		return acc;
	endfunction

	// One pipeline step: shift in a pixel, maybe produce one result
	function automatic bit window_advance(logic [PIX_W-1:0] pix, output filtered_t res);
		int unsigned     w;
		int unsigned     h;
		int unsigned     c;
		int unsigned     r;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		bit              emit;
		longint          acc;
		w    = eff_width();
		h    = eff_height();
		c    = col_ptr;
		r    = row_ptr;
		emit = 0;
		acc  = 0;
		res  = '0;
		// right-edge result of the row before last
		if (c == 0 && r >= 2) begin
			acc  = window_sum(3, 6, 6, r - 2, w - 1, h);
			emit = 1;
		end
		top           = older_line[c];
		mid           = newer_line[c];
		older_line[c] = mid;
		newer_line[c] = pix;
		for (int i = 0; i < 6; i++)
			win_pix[i] = win_pix[i + 3];
		win_pix[6] = top;
		win_pix[7] = mid;
		win_pix[8] = pix;
		if (c >= 1 && r >= 1) begin
			acc  = window_sum(0, 3, 6, r - 1, c - 1, h);
			emit = 1;
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
		end
		col_ptr = c;
		row_ptr = r;
		if (!emit)
			return 0;
		res.value = acc[OUT_W-1:0];
		if (result_idx + 1 >= w * h) begin
			res.last   = 1'b1;
			col_ptr    = 0;
			row_ptr    = 0;
			result_idx = 0;
		end else begin
			res.last = 1'b0;
			result_idx++;
		end
		return 1;
	endfunction

	function automatic void predict_request(action_t act, logic [PIX_W-1:0] pix);
		filtered_t res;
		int unsigned h;
		h = eff_height();
		if (act == ACT_PIXEL) begin
			// pixels past a complete frame are dropped
			if (row_ptr >= h)
				return;
			if (window_advance(pix, res))
				expected_filtered.push_back(res);
		end else begin
			// flush only counts once the frame is in
			if (row_ptr < h)
				return;
			for (int i = 0; i < 2; i++) begin
				if (window_advance('0, res)) begin
					expected_filtered.push_back(res);
					break;
				end
			end
		end
	endfunction

	// ---------------------------------------------------------------
	// Shared driving tasks
	// ---------------------------------------------------------------

	// Send one request; returns at the edge it is accepted, tvalid left high
	task automatic send_req(action_t act, logic [PIX_W-1:0] pix);
		int gap;
		gap = src_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		s_axis_tuser  <= act;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_request(act, pix);
	endtask

	// Stop sending and let every pending result come out
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_filtered.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_FRAME_WIDTH:  width_reg     = val[DIM_CFG_W-1:0];
			CFG_FRAME_HEIGHT: height_reg    = val[DIM_CFG_W-1:0];
			CFG_KERNEL_TOP:   kernel_reg[0] = val[KROW_W-1:0];
			CFG_KERNEL_MID:   kernel_reg[1] = val[KROW_W-1:0];
			CFG_KERNEL_BOT:   kernel_reg[2] = val[KROW_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(int w, int h);
		write_reg(CFG_FRAME_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
	endtask

	// Coefficients biased toward the extremes and small values
	function automatic logic [KROW_W-1:0] draw_kernel_row();
		logic [KROW_W-1:0] krow;
		for (int slot = 0; slot < 3; slot++) begin
			case ($urandom_range(0, 5))
				0: krow[COEF_W*slot +: COEF_W] = 16'h8000;
				1: krow[COEF_W*slot +: COEF_W] = 16'h7FFF;
				2: krow[COEF_W*slot +: COEF_W] = 16'h0000;
				3: krow[COEF_W*slot +: COEF_W] = 16'($urandom_range(0, 8) + 32'hFFFC);
				default: krow[COEF_W*slot +: COEF_W] = 16'($urandom());
			endcase
		end
		return krow;
	endfunction

	task automatic load_random_kernel();
		write_reg(CFG_KERNEL_TOP, draw_kernel_row());
		write_reg(CFG_KERNEL_MID, draw_kernel_row());
		write_reg(CFG_KERNEL_BOT, draw_kernel_row());
	endtask

	task automatic feed_frame();
		while (row_ptr < eff_height())
			send_req(ACT_PIXEL, $urandom_range(0, 255));
	endtask

	task automatic flush_frame();
		while (row_ptr >= eff_height())
			send_req(ACT_FLUSH, $urandom_range(0, 255));
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Reset kernel (identity), early flush and trailing pixel both dropped
	task automatic test_basic();
		logic [PIX_W-1:0] pix [6];
		pix = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};
		set_geometry(3, 2);
		send_req(ACT_FLUSH, 8'hFF);
		foreach (pix[i])
			send_req(ACT_PIXEL, pix[i]);
		send_req(ACT_PIXEL, 8'h7E);
		flush_frame();
		wait_idle();
	endtask

	// Zero geometry acts as 1x1; most negative and most positive sums
	task automatic test_sum_extremes();
		set_geometry(0, 0);
		write_reg(CFG_KERNEL_TOP, 48'h8000_8000_8000);
		write_reg(CFG_KERNEL_MID, 48'h8000_8000_8000);
		write_reg(CFG_KERNEL_BOT, 48'h8000_8000_8000);
		send_req(ACT_PIXEL, 8'hFF);
		flush_frame();
		wait_idle();
		write_reg(CFG_KERNEL_TOP, 48'h7FFF_7FFF_7FFF);
		write_reg(CFG_KERNEL_MID, 48'h7FFF_7FFF_7FFF);
		write_reg(CFG_KERNEL_BOT, 48'h7FFF_7FFF_7FFF);
		send_req(ACT_PIXEL, 8'hFF);
		flush_frame();
		wait_idle();
	endtask

	// Single-row frame: first flush takes an internal empty step
	task automatic test_one_row();
		set_geometry(3, 1);
		load_random_kernel();
		feed_frame();
		flush_frame();
		wait_idle();
	endtask

	// Kernel and width changed mid-frame while the block is idle
	task automatic test_mid_frame_config();
		set_geometry(4, 3);
		load_random_kernel();
		repeat (5) send_req(ACT_PIXEL, $urandom_range(0, 255));
		wait_idle();
		write_reg(CFG_KERNEL_TOP, draw_kernel_row());
		write_reg(CFG_FRAME_WIDTH, 3);
		feed_frame();
		flush_frame();
		wait_idle();
	endtask

	// Oversized geometry saturates to the maximum width and height
	task automatic test_max_geometry();
		src_idle = 1'b0;
		snk_idle = 1'b1;
		set_geometry(2047, 1);
		load_random_kernel();
		feed_frame();
		flush_frame();
		wait_idle();
		snk_idle = 1'b0;
		set_geometry(1, 2047);
		feed_frame();
		flush_frame();
		wait_idle();
		set_geometry(MAX_W, 2);
		feed_frame();
		flush_frame();
		wait_idle();
	endtask

	// Random frames: mostly well-formed, some dropped requests and pauses
	task automatic test_random_frames();
		int  counted;
		int  w;
		int  h;
		bit  reconfig;
		counted  = 0;
		reconfig = 1'b1;
		while (counted < RAND_ITEMS) begin
			if (reconfig) begin
				wait_idle();
				case ($urandom_range(0, 19))
					0:       w = 0;
					1:       w = $urandom_range(33, 200);
					default: w = $urandom_range(1, 12);
				endcase
				case ($urandom_range(0, 19))
					0:       h = 0;
					1:       h = $urandom_range(9, 24);
					default: h = $urandom_range(1, 8);
				endcase
				set_geometry(w, h);
				if ($urandom_range(0, 1))
					load_random_kernel();
			end
			src_idle = ($urandom_range(0, 2) != 0);
			snk_idle = ($urandom_range(0, 2) != 0);
			while (row_ptr < eff_height()) begin
				if ($urandom_range(0, 49) == 0)
					send_req(ACT_FLUSH, $urandom_range(0, 255));
				send_req(ACT_PIXEL, $urandom_range(0, 255));
				counted++;
				if ($urandom_range(0, 299) == 0)
					wait_idle();
			end
			if ($urandom_range(0, 4) == 0)
				send_req(ACT_PIXEL, $urandom_range(0, 255));
			while (row_ptr >= eff_height()) begin
				send_req(ACT_FLUSH, $urandom_range(0, 255));
				counted++;
			end
			reconfig = ($urandom_range(0, 2) != 0);
		end
		wait_idle();
	endtask

	// ---------------------------------------------------------------
	// Result side: random stalls and in-order check
	// ---------------------------------------------------------------

	initial begin : result_sink
		int stall;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = snk_idle ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
		end
	end

	task automatic note_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin : check_results
		filtered_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_filtered.size() == 0) begin
				note_mismatch($sformatf("unexpected result tdata=%h tlast=%b",
					m_axis_tdata, m_axis_tlast));
			end else begin
				want = expected_filtered.pop_front();
				if (m_axis_tdata[OUT_W-1:0] !== want.value)
					note_mismatch($sformatf("filtered_value expected %0d got %0d",
						$signed(want.value), $signed(m_axis_tdata[OUT_W-1:0])));
				if (m_axis_tdata[TDATA_OUT_W-1:OUT_W] !== '0)
					note_mismatch($sformatf("tdata pad expected 0 got %h",
						m_axis_tdata[TDATA_OUT_W-1:OUT_W]));
				if (m_axis_tlast !== want.last)
					note_mismatch($sformatf("frame_end expected %b got %b",
						want.last, m_axis_tlast));
			end
		end
	end

	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------

	initial begin
		mismatch_count = 0;
		src_idle       = 1'b1;
		snk_idle       = 1'b1;
		reset_prediction();
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= ACT_PIXEL;
		cfg_wr_en     <= 1'b0;
		cfg_index     <= CFG_FRAME_WIDTH;
		cfg_wr_data   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic();
		test_sum_extremes();
		test_one_row();
		test_mid_frame_config();
		test_max_geometry();
		test_random_frames();

		wait_idle();
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
